// File: rtl/fbrk_pkg.sv
// ----------------------------------------------------------------------------
// fbrk_pkg
// Types, constants and the exp table generator of the falling-body RK4 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fbrk_pkg;

  localparam int DW              = 48;
  localparam int ACC_W           = 51;
  localparam int STEP_W          = 47;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int EXP_DEPTH_DEF   = 256;
  localparam int CELL_COUNT      = 4;

  localparam logic [60:0] LOG2E_Q60 = 61'h171547652B82FE17;
  localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79B;
  localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;

  typedef enum logic [0:0] {
    REG_STEP_TIME  = 1'b0,
    REG_DRAG_DECAY = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DW-1:0] altitude;
    logic [DW-1:0] velocity;
    logic [DW-1:0] ballistic_coef;
    logic [DW-1:0] noise_altitude;
    logic [DW-1:0] noise_velocity;
    logic [DW-1:0] noise_coef;
  } in_t;

  typedef struct packed {
    logic [DW-1:0] next_altitude;
    logic [DW-1:0] next_velocity;
    logic [DW-1:0] next_coef;
    logic          saturated;
  } out_t;

  // state point handed from cell to cell
  typedef struct packed {
    logic [2:0][DW-1:0]    x;
    logic [2:0][DW-1:0]    n;
    logic [2:0][ACC_W-1:0] acc;
    logic [2:0][DW-1:0]    xt;
    logic                  sat;
  } pt_t;

  // e^(-x) in Q1.60 by a series through the x^30 term, x in Q4.60
  function automatic logic [60:0] pow2_of(input logic [63:0] x);
    logic [63:0]  term;
    logic [63:0]  plus;
    logic [63:0]  minus;
    logic [127:0] prod;
    term  = ONE_Q60;
    plus  = ONE_Q60;
    minus = 64'd0;
    for (int n = 1; n <= 30; n++) begin
      prod = {64'd0, term} * {64'd0, x};
      term = prod[123:60] / 64'(n);
      if ((n & 1) == 1) begin
        minus = minus + term;
      end else begin
        plus = plus + term;
      end
    end
    return 61'(plus - minus);
  endfunction

endpackage

`default_nettype wire

// File: rtl/fbrk_delay.sv
// ----------------------------------------------------------------------------
// fbrk_delay
// Enabled shift line that keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrk_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule

`default_nettype wire

// File: rtl/fbrk_mul.sv
// ----------------------------------------------------------------------------
// fbrk_mul
// Unsigned multiplier split in halves: partial products, then their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrk_mul #(
  parameter int WA = 48,
  parameter int WB = 48
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [WA-1:0]   a,
  input  wire logic [WB-1:0]   b,
  output logic      [WA+WB-1:0] p
);

  localparam int LA = WA / 2;
  localparam int HA = WA - LA;
  localparam int LB = WB / 2;
  localparam int HB = WB - LB;
  localparam int PW = WA + WB;

  logic [LA+LB-1:0] ll_r;
  logic [LA+HB-1:0] lh_r;
  logic [HA+LB-1:0] hl_r;
  logic [HA+HB-1:0] hh_r;
  logic [PW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a[LA-1:0]  * b[LB-1:0];
      lh_r <= a[LA-1:0]  * b[WB-1:LB];
      hl_r <= a[WA-1:LA] * b[LB-1:0];
      hh_r <= a[WA-1:LA] * b[WB-1:LB];
      p_r  <= PW'(ll_r) + (PW'(lh_r) << LB) + (PW'(hl_r) << LA) + (PW'(hh_r) << (LA + LB));
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: rtl/fbrk_mulq.sv
// ----------------------------------------------------------------------------
// fbrk_mulq
// Signed fixed-point product: magnitude multiply, shift, truncate toward
// zero, saturate to 48 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module fbrk_mulq
  import fbrk_pkg::*;
#(
  parameter int WA = 48,
  parameter int WB = 48,
  parameter int SH = 24
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [WA-1:0] a,
  input  wire logic signed [WB-1:0] b,
  output logic             [DW-1:0] p,
  output logic                      clip
);

  localparam int PW = WA + WB;
  localparam logic [PW-1:0] LIM_NEG = PW'(48'h8000_0000_0000);
  localparam logic [PW-1:0] LIM_POS = PW'(48'h7FFF_FFFF_FFFF);

  logic [WA-1:0] ma_r;
  logic [WB-1:0] mb_r;
  logic [2:0]    neg_r;
  logic [PW-1:0] prod;
  logic [PW-1:0] mag;
  logic [DW-1:0] p_nxt;
  logic          clip_nxt;
  logic [DW-1:0] p_r;
  logic          clip_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= a[WA-1] ? WA'(-a) : WA'(a);
      mb_r  <= b[WB-1] ? WB'(-b) : WB'(b);
      neg_r <= {neg_r[1:0], a[WA-1] ^ b[WB-1]};
      p_r   <= p_nxt;
      clip_r <= clip_nxt;
    end
  end

  fbrk_mul #(.WA(WA), .WB(WB)) u_mul (
    .clk(clk), .en(en), .a(ma_r), .b(mb_r), .p(prod)
  );

  always_comb begin
    mag = prod >> SH;
    if (neg_r[2]) begin
      clip_nxt = mag > LIM_NEG;
      p_nxt    = clip_nxt ? 48'h8000_0000_0000 : DW'(-mag[DW-1:0]);
    end else begin
      clip_nxt = mag > LIM_POS;
      p_nxt    = clip_nxt ? 48'h7FFF_FFFF_FFFF : mag[DW-1:0];
    end
  end

  assign p    = p_r;
  assign clip = clip_r;

endmodule

`default_nettype wire

// File: rtl/fbrk_cell.sv
// ----------------------------------------------------------------------------
// fbrk_cell
// One RK4 stage: derivative at the incoming point, weighted accumulate,
// next stage point (or final state in the last cell).
// ----------------------------------------------------------------------------
`default_nettype none

module fbrk_cell
  import fbrk_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF,
  parameter int STAGE           = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic [DW-1:0] gamma,
  input  wire logic [DW-1:0] coef,
  input  wire logic          in_valid,
  input  wire pt_t           in_pt,
  output logic               out_valid,
  output pt_t                out_pt
);

  localparam int LAT  = 28;
  localparam int LOGD = $clog2(EXP_TABLE_DEPTH);
  localparam int KW   = 49 - FRAC_BITS;
  localparam int EW   = FRAC_BITS + 1;
  localparam int WGT  = (STAGE == 1 || STAGE == 2) ? 2 : 1;
  localparam bit LAST = (STAGE == CELL_COUNT - 1);

  function automatic logic [DW:0] sat_sum(input logic signed [DW:0] s);
    logic [DW:0] r;
    if (s > $signed({2'b00, {(DW-1){1'b1}}})) begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else if (s < $signed({2'b11, {(DW-1){1'b0}}})) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, s[DW-1:0]};
    end
    return r;
  endfunction

  logic [60:0] tab [EXP_TABLE_DEPTH+1];

  for (genvar g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] XG = (LN2_Q60 / EXP_TABLE_DEPTH) * g
                               + ((LN2_Q60 % EXP_TABLE_DEPTH) * g) / EXP_TABLE_DEPTH;
    assign tab[g] = pow2_of(XG);
  end

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  always_comb vld_nxt = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];

  // exponent argument
  logic [DW-1:0]    habs_r;
  logic             hneg_r;
  logic             hneg3;
  logic [2*DW-1:0]  gprod;
  logic [DW-1:0]    arg_r;
  logic             cneg_r;
  logic [DW+60:0]   lprod;
  logic [48:0]      t;
  logic [LOGD:0]    idx_lo;
  logic [LOGD:0]    idx_hi;
  logic [60:0]      ti_r;
  logic [60:0]      d_r;
  logic [FRAC_BITS-1:0] r_r;
  logic [KW-1:0]    k_r;
  logic [60+FRAC_BITS:0] dprod;
  logic [60:0]      ti9;
  logic [KW-1:0]    k9;
  logic [60:0]      v;
  logic [5:0]       sh;
  logic [EW-1:0]    e_nxt;
  logic [EW-1:0]    e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      habs_r <= in_pt.xt[0][DW-1] ? DW'(-in_pt.xt[0]) : in_pt.xt[0];
      hneg_r <= in_pt.xt[0][DW-1];
      arg_r  <= hneg3 ? '0 : gprod[2*DW-1:DW];
      cneg_r <= hneg3 && (gprod[2*DW-1:DW] != '0);
      ti_r   <= tab[idx_lo];
      d_r    <= (tab[idx_lo] > tab[idx_hi]) ? tab[idx_lo] - tab[idx_hi] : '0;
      r_r    <= {t[FRAC_BITS-LOGD-1:0], {LOGD{1'b0}}};
      k_r    <= t[48:FRAC_BITS];
      e_r    <= e_nxt;
    end
  end

  fbrk_mul #(.WA(DW), .WB(DW)) u_gmul (
    .clk(clk), .en(en), .a(gamma), .b(habs_r), .p(gprod)
  );

  fbrk_delay #(.W(1), .N(2)) u_dneg (.clk(clk), .en(en), .d(hneg_r), .q(hneg3));

  fbrk_mul #(.WA(DW), .WB(61)) u_lmul (
    .clk(clk), .en(en), .a(arg_r), .b(LOG2E_Q60), .p(lprod)
  );

  assign t      = lprod[DW+60:60];
  assign idx_lo = {1'b0, t[FRAC_BITS-1 -: LOGD]};
  assign idx_hi = idx_lo + 1'b1;

  fbrk_mul #(.WA(61), .WB(FRAC_BITS)) u_dmul (
    .clk(clk), .en(en), .a(d_r), .b(r_r), .p(dprod)
  );

  fbrk_delay #(.W(61), .N(2)) u_dti (.clk(clk), .en(en), .d(ti_r), .q(ti9));
  fbrk_delay #(.W(KW), .N(2)) u_dk  (.clk(clk), .en(en), .d(k_r),  .q(k9));

  always_comb begin
    v  = ti9 - dprod[60+FRAC_BITS:FRAC_BITS];
    sh = k9[5:0] + 6'(60 - FRAC_BITS);
    if (k9 >= KW'(FRAC_BITS + 4)) begin
      e_nxt = '0;
    end else begin
      e_nxt = EW'(v >> sh);
    end
  end

  // drag term
  pt_t           s10, s14, s18, s22;
  logic [DW-1:0] w1, w2, w3;
  logic          f1, f2, f3;
  logic          f1d, f2d, cnegd;

  fbrk_delay #(.W($bits(pt_t)), .N(10)) u_s10 (.clk(clk), .en(en), .d(in_pt), .q(s10));
  fbrk_delay #(.W($bits(pt_t)), .N(4))  u_s14 (.clk(clk), .en(en), .d(s10),   .q(s14));
  fbrk_delay #(.W($bits(pt_t)), .N(4))  u_s18 (.clk(clk), .en(en), .d(s14),   .q(s18));
  fbrk_delay #(.W($bits(pt_t)), .N(4))  u_s22 (.clk(clk), .en(en), .d(s18),   .q(s22));

  fbrk_mulq #(.WA(EW+1), .WB(DW), .SH(FRAC_BITS)) u_q1 (
    .clk(clk), .en(en), .a($signed({1'b0, e_r})), .b($signed(s10.xt[1])), .p(w1), .clip(f1)
  );
  fbrk_mulq #(.WA(DW), .WB(DW), .SH(FRAC_BITS)) u_q2 (
    .clk(clk), .en(en), .a($signed(w1)), .b($signed(s14.xt[1])), .p(w2), .clip(f2)
  );
  fbrk_mulq #(.WA(DW), .WB(DW), .SH(FRAC_BITS)) u_q3 (
    .clk(clk), .en(en), .a($signed(w2)), .b($signed(s18.xt[2])), .p(w3), .clip(f3)
  );

  fbrk_delay #(.W(1), .N(18)) u_dcn (.clk(clk), .en(en), .d(cneg_r), .q(cnegd));
  fbrk_delay #(.W(1), .N(8))  u_df1 (.clk(clk), .en(en), .d(f1),     .q(f1d));
  fbrk_delay #(.W(1), .N(4))  u_df2 (.clk(clk), .en(en), .d(f2),     .q(f2d));

  // derivative and accumulate
  pt_t         st_nxt;
  pt_t         st_r;
  logic [DW:0] k0s;
  logic [DW:0] k1s;

  always_comb begin
    k0s = sat_sum($signed({s22.n[0][DW-1], s22.n[0]}) - $signed({s22.xt[1][DW-1], s22.xt[1]}));
    k1s = sat_sum($signed({s22.n[1][DW-1], s22.n[1]}) - $signed({w3[DW-1], w3}));
    st_nxt       = s22;
    st_nxt.xt[0] = k0s[DW-1:0];
    st_nxt.xt[1] = k1s[DW-1:0];
    st_nxt.xt[2] = s22.n[2];
    for (int j = 0; j < 3; j++) begin
      st_nxt.acc[j] = s22.acc[j]
                    + (ACC_W'($signed(st_nxt.xt[j])) << (WGT - 1));
    end
    st_nxt.sat = s22.sat | cnegd | f1d | f2d | f3 | k0s[DW] | k1s[DW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  // next stage point
  pt_t             s27;
  logic [2:0][DW-1:0] pq;
  logic [2:0]      fq;
  pt_t             o_nxt;
  pt_t             o_r;
  logic [DW:0]     xs [3];

  fbrk_delay #(.W($bits(pt_t)), .N(4)) u_s27 (.clk(clk), .en(en), .d(st_r), .q(s27));

  for (genvar j = 0; j < 3; j++) begin : g_lane
    logic signed [ACC_W-1:0] opnd;
    assign opnd = LAST ? $signed(st_r.acc[j]) : ACC_W'($signed(st_r.xt[j]));
    fbrk_mulq #(.WA(DW), .WB(ACC_W), .SH(FRAC_BITS)) u_qs (
      .clk(clk), .en(en), .a($signed(coef)), .b(opnd), .p(pq[j]), .clip(fq[j])
    );
  end

  always_comb begin
    o_nxt = s27;
    o_nxt.sat = s27.sat | (|fq);
    for (int j = 0; j < 3; j++) begin
      xs[j] = sat_sum($signed({s27.x[j][DW-1], s27.x[j]}) + $signed({pq[j][DW-1], pq[j]}));
      o_nxt.xt[j] = xs[j][DW-1:0];
      o_nxt.sat   = o_nxt.sat | xs[j][DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign out_pt = o_r;

endmodule

`default_nettype wire

// File: rtl/falling_body_rk4_step_unit.sv
// Each accepted input beat passes through four RK stage cells and then
// the output register before it leaves as a result beat.
// Throughput: one beat per cycle while not stalled (fully pipelined cell chain).
// The pipeline stops only when its last stage and the output register both
// hold a result that is stalled.
// Reset (rst_n low, synchronous) clears all valid bits and loads config defaults.
// ----------------------------------------------------------------------------
// falling_body_rk4_step_unit
// One RK4 step of the falling-body drag model over a chain of stage cells.
// ----------------------------------------------------------------------------
`default_nettype none

module falling_body_rk4_step_unit
  import fbrk_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire in_t           in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output out_t               out_data,
  input  wire logic          cfg_we,
  input  wire cfg_reg_t      cfg_index,
  input  wire logic [DW-1:0] cfg_wdata
);

  localparam logic [47:0] SIXTH_M = 48'(((64'd1 << 50) + 64'd5) / 64'd6);

  logic [STEP_W-1:0] step_time_r;
  logic [DW-1:0]     drag_decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r  <= STEP_W'(64'd1 << FRAC_BITS);
      drag_decay_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_TIME:  step_time_r  <= cfg_wdata[STEP_W-1:0];
        REG_DRAG_DECAY: drag_decay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Ts/6 by reciprocal multiply
  logic [STEP_W+47:0] sprod;
  logic [44:0]        sixth_r;

  fbrk_mul #(.WA(STEP_W), .WB(48)) u_sixth (
    .clk(clk), .en(1'b1), .a(step_time_r), .b(SIXTH_M), .p(sprod)
  );

  always_ff @(posedge clk) begin
    sixth_r <= sprod[STEP_W+47:50];
  end

  logic [CELL_COUNT-1:0][DW-1:0] coef;
  assign coef[0] = {2'b00, step_time_r[STEP_W-1:1]};
  assign coef[1] = {2'b00, step_time_r[STEP_W-1:1]};
  assign coef[2] = {1'b0, step_time_r};
  assign coef[3] = {3'b000, sixth_r};

  logic adv;
  logic out_valid_r;
  out_t out_data_r;
  pt_t  pin;
  pt_t  cpt [CELL_COUNT+1];
  logic cvld [CELL_COUNT+1];

  always_comb begin
    pin.x   = {in_data.ballistic_coef, in_data.velocity, in_data.altitude};
    pin.n   = {in_data.noise_coef, in_data.noise_velocity, in_data.noise_altitude};
    pin.xt  = pin.x;
    pin.acc = '0;
    pin.sat = 1'b0;
  end

  assign cpt[0]  = pin;
  assign cvld[0] = in_valid;

  for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
    fbrk_cell #(
      .FRAC_BITS(FRAC_BITS), .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH), .STAGE(c)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .gamma(drag_decay_r), .coef(coef[c]),
      .in_valid(cvld[c]), .in_pt(cpt[c]), .out_valid(cvld[c+1]), .out_pt(cpt[c+1])
    );
  end

  assign adv      = !(cvld[CELL_COUNT] && out_valid_r && out_stall);
  assign in_stall = !adv;

  logic out_load;
  assign out_load = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= cvld[CELL_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.next_altitude <= cpt[CELL_COUNT].xt[0];
      out_data_r.next_velocity <= cpt[CELL_COUNT].xt[1];
      out_data_r.next_coef     <= cpt[CELL_COUNT].xt[2];
      out_data_r.saturated     <= cpt[CELL_COUNT].sat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
